/* rtl/core/gnms_pkg.sv */
// Shared constants, codes and the angle-to-sector function for the NMS block.
package gnms_pkg;

    // Default sizing
    localparam int unsigned DEF_MAX_WIDTH = 1024;
    localparam int unsigned DEF_MAG_BITS  = 16;

    // Field and register widths
    localparam int unsigned MAG_W        = 16;
    localparam int unsigned ANGLE_W      = 16;
    localparam int unsigned IMG_W_BITS   = 11;
    localparam int unsigned IMG_H_BITS   = 13;
    localparam int unsigned ROW_BITS     = 12;
    localparam int unsigned HEIGHT_LIMIT = 4096;

    localparam logic [IMG_W_BITS-1:0] WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_BITS-1:0] HEIGHT_RST = 13'd480;

    // Angle constants, Q3.13 radians
    localparam logic signed [ANGLE_W:0] PI_Q   = 17'sd25736;
    localparam logic signed [ANGLE_W:0] SECT_A = 17'sd3217;
    localparam logic signed [ANGLE_W:0] SECT_B = 17'sd9651;
    localparam logic signed [ANGLE_W:0] SECT_C = 17'sd16085;
    localparam logic signed [ANGLE_W:0] SECT_D = 17'sd22519;

    // Input word kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Configuration register indexes (address bit 2)
    typedef enum logic {
        REG_IMG_WIDTH  = 1'b0,
        REG_IMG_HEIGHT = 1'b1
    } t_reg_idx;

    // Direction sectors
    typedef enum logic [1:0] {
        SECT_HORZ    = 2'd0,  // left / right
        SECT_DIAG_DN = 2'd1,  // up-left / down-right
        SECT_VERT    = 2'd2,  // up / down
        SECT_DIAG_UP = 2'd3   // up-right / down-left
    } t_sector;

    function automatic t_sector f_sector(input logic signed [ANGLE_W-1:0] angle);
        logic signed [ANGLE_W:0] a;
        t_sector s;
        a = (ANGLE_W+1)'(angle);
        // add pi to negative angles; anything still outside [0, pi) maps to horizontal
        if (a < 0) begin
            a = a + PI_Q;
        end
        if (a >= SECT_D || a < SECT_A) begin
            s = SECT_HORZ;
        end else if (a < SECT_B) begin
            s = SECT_DIAG_DN;
        end else if (a < SECT_C) begin
            s = SECT_VERT;
        end else begin
            s = SECT_DIAG_UP;
        end
        return s;
    endfunction

endpackage

/* rtl/core/gnms_stream_if.sv */
// Valid/ready stream interfaces for pixel input words and result output words.
interface gnms_pix_if import gnms_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [MAG_W-1:0]          grad_magnitude;
    logic signed [ANGLE_W-1:0] grad_angle;

    modport source (output valid, req_type, grad_magnitude, grad_angle, input ready);
    modport sink   (input valid, req_type, grad_magnitude, grad_angle, output ready);
endinterface

interface gnms_res_if import gnms_pkg::*;;
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] kept_magnitude;
    logic             last_in_step;
    logic             end_of_frame;

    modport source (output valid, kept_magnitude, last_in_step, end_of_frame, input ready);
    modport sink   (input valid, kept_magnitude, last_in_step, end_of_frame, output ready);
endinterface

/* rtl/core/gnms_ram.sv */
// Generic RAM: one write port, two registered read ports sharing a read enable.
module gnms_ram #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // hold read data while disabled
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

/* rtl/core/gradient_non_max_suppression.sv */
// Streaming 3x3 non-maximum suppression over three rotating line buffers.
//
// Usage: pixel words arrive in raster order on i_pix (valid/ready), each with a
// gradient magnitude and a Q3.13 angle. Result words leave on o_res. A pixel at
// column c of row r >= 1 yields the result for column c-1 of row r-1; the last
// column of a row also yields the result for column c of row r-1. After the last
// pixel of a frame, one drain word per column flushes the bottom row; the last
// drain result carries end_of_frame and the block starts a new frame. Pixels
// after a complete frame and drain words before one are consumed with no result.
// Frame width and height are set through the APB port (byte addresses 0 and 4);
// the user must write them only while the block is idle; the block does not enforce it.
// A result word passes the registered line buffer read, then the compare into a
// two-entry output register, before it is offered on o_res.
// Throughput: one word per cycle while o_res is ready; the last pixel of a row,
// which yields two results, holds the input while the output drains.
// Reset clears counters, buffer roles, the pipeline and the output register;
// widths go to 640x480. Line buffers are not cleared. When o_res stalls, the output
// register holds its words and i_pix drops ready while a compare-stage word waits.
module gradient_non_max_suppression import gnms_pkg::*; #(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int unsigned MAG_BITS  = DEF_MAG_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gnms_pix_if.sink    i_pix,
    gnms_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned BW = MAG_BITS + 2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PIXEL,
        KIND_DRAIN
    } t_kind;

    typedef struct packed {
        logic [MAG_BITS-1:0] up;
        logic [MAG_BITS-1:0] mid;
        logic [MAG_BITS-1:0] dn;
        t_sector             sect;
    } t_col;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
        logic             eof;
    } t_word;

    function automatic logic [1:0] f_inc3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    // keep the center magnitude if no neighbor along its sector is larger
    function automatic logic [MAG_BITS-1:0] f_nms(input t_col c, input t_col l,
                                                  input t_col r);
        logic [MAG_BITS-1:0] na;
        logic [MAG_BITS-1:0] nb;
        case (c.sect)
            SECT_HORZ: begin
                na = l.mid;
                nb = r.mid;
            end
            SECT_DIAG_DN: begin
                na = l.up;
                nb = r.dn;
            end
            SECT_VERT: begin
                na = c.up;
                nb = c.dn;
            end
            SECT_DIAG_UP: begin
                na = r.up;
                nb = l.dn;
            end
            default: begin
                na = l.mid;
                nb = r.mid;
            end
        endcase
        return (c.mid >= na && c.mid >= nb) ? c.mid : '0;
    endfunction

    // Configuration
    logic [IMG_W_BITS-1:0] r_img_w;
    logic [IMG_H_BITS-1:0] r_img_h;
    t_reg_idx              reg_idx;
    logic                  cfg_wr;

    // Frame position
    logic [CW-1:0]       r_col;
    logic [ROW_BITS-1:0] r_row;
    logic [CW-1:0]       r_drain;
    logic                r_frame_done;
    logic [1:0]          r_cur;
    logic [CW-1:0]       wlast;
    logic [ROW_BITS-1:0] hlast;
    logic                col_last;
    logic                row_last;
    logic                drain_last;

    // Input side
    logic          in_acc;
    logic          do_pix;
    logic          do_drain;
    logic [BW-1:0] wdata;
    logic [CW-1:0] raddr_a;
    logic [CW-1:0] raddr_b;
    logic [BW-1:0] rd_a [3];
    logic [BW-1:0] rd_b [3];

    // Compare stage
    logic                r_s1_vld;
    t_kind               r_s1_kind;
    logic [MAG_BITS-1:0] r_s1_mag;
    logic                r_s1_top;
    logic                r_s1_emit0;
    logic                r_s1_emit1;
    logic                r_s1_lc0;
    logic                r_s1_lc1;
    logic                r_s1_first;
    logic                r_s1_eof;
    logic [1:0]          r_s1_mid;
    logic [1:0]          r_s1_abv;
    t_col                r_win_a;
    t_col                r_win_b;
    t_col                col_n;
    t_col                col_e;
    logic [BW-1:0]       mid_a;
    logic [BW-1:0]       abv_a;
    logic [BW-1:0]       mid_b;
    logic [BW-1:0]       abv_b;
    logic [MAG_BITS-1:0] res0;
    logic [MAG_BITS-1:0] res1;
    logic [MAG_BITS-1:0] resd;
    t_word               w0;
    t_word               w1;
    logic [1:0]          nres;
    logic                s1_adv;

    // Output register
    logic [1:0] r_out_cnt;
    t_word      r_out0;
    t_word      r_out1;
    logic       out_free;

    //------------------------------------------------------------------
    // APB configuration
    //------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RST;
            r_img_h <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_IMG_WIDTH:  r_img_w <= pwdata[IMG_W_BITS-1:0];
                REG_IMG_HEIGHT: r_img_h <= pwdata[IMG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMG_WIDTH:  prdata = 32'(r_img_w);
            REG_IMG_HEIGHT: prdata = 32'(r_img_h);
            default:        prdata = '0;
        endcase
    end

    // Last column and last row indexes, clamped into range
    always_comb begin
        if (r_img_w == '0) begin
            wlast = '0;
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            wlast = CW'(MAX_WIDTH - 1);
        end else begin
            wlast = CW'(r_img_w - 11'd1);
        end
        if (r_img_h == '0) begin
            hlast = '0;
        end else if (r_img_h > IMG_H_BITS'(HEIGHT_LIMIT)) begin
            hlast = ROW_BITS'(HEIGHT_LIMIT - 1);
        end else begin
            hlast = ROW_BITS'(r_img_h - 13'd1);
        end
    end

    //------------------------------------------------------------------
    // Input word: counters, line buffer write and read
    //------------------------------------------------------------------
    assign col_last   = r_col >= wlast;
    assign row_last   = r_row >= hlast;
    assign drain_last = r_drain >= wlast;

    assign in_acc   = i_pix.valid && i_pix.ready;
    assign do_pix   = in_acc && (i_pix.req_type == REQ_PIXEL) && !r_frame_done;
    assign do_drain = in_acc && (i_pix.req_type == REQ_DRAIN) && r_frame_done;

    assign wdata   = {f_sector(i_pix.grad_angle), MAG_BITS'(i_pix.grad_magnitude)};
    assign raddr_a = r_frame_done ? r_drain : r_col;
    assign raddr_b = drain_last ? r_drain : CW'(r_drain + 1'b1);

    // Three physical rows; r_cur is the row being written, the next one up
    // holds the row above and the one after that the middle row.
    for (genvar k = 0; k < 3; k++) begin : g_row
        gnms_ram #(
            .WIDTH (BW),
            .DEPTH (MAX_WIDTH)
        ) u_row (
            .i_clk     (i_clk),
            .i_we      (do_pix && (r_cur == 2'(k))),
            .i_waddr   (r_col),
            .i_wdata   (wdata),
            .i_re      (in_acc),
            .i_raddr_a (raddr_a),
            .i_raddr_b (raddr_b),
            .o_rdata_a (rd_a[k]),
            .o_rdata_b (rd_b[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_drain      <= '0;
            r_frame_done <= 1'b0;
            r_cur        <= '0;
            r_s1_vld     <= 1'b0;
        end else begin
            if (do_pix) begin
                if (col_last) begin
                    r_col <= '0;
                    r_cur <= f_inc3(r_cur);
                    if (row_last) begin
                        r_frame_done <= 1'b1;
                    end else begin
                        r_row <= r_row + 12'd1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (do_drain) begin
                if (drain_last) begin
                    r_col        <= '0;
                    r_row        <= '0;
                    r_drain      <= '0;
                    r_frame_done <= 1'b0;
                end else begin
                    r_drain <= r_drain + 1'b1;
                end
            end
            if (i_pix.ready) begin
                r_s1_vld <= in_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind  <= do_pix ? KIND_PIXEL : (do_drain ? KIND_DRAIN : KIND_NONE);
            r_s1_mag   <= MAG_BITS'(i_pix.grad_magnitude);
            r_s1_top   <= r_frame_done ? (r_row == '0) : (r_row == 12'd1);
            r_s1_emit0 <= (r_row != '0) && (r_col != '0);
            r_s1_emit1 <= (r_row != '0) && col_last;
            r_s1_lc0   <= r_col == CW'(1);
            r_s1_lc1   <= r_col == '0;
            r_s1_first <= r_drain == '0;
            r_s1_eof   <= drain_last;
            r_s1_abv   <= f_inc3(r_cur);
            r_s1_mid   <= f_inc3(f_inc3(r_cur));
        end
    end

    //------------------------------------------------------------------
    // Compare stage
    //------------------------------------------------------------------
    assign mid_a = rd_a[r_s1_mid];
    assign abv_a = rd_a[r_s1_abv];
    assign mid_b = rd_b[r_s1_mid];
    assign abv_b = rd_b[r_s1_abv];

    always_comb begin
        // newest column: above/middle from the buffers, below is the incoming
        // pixel, or the middle row itself on the bottom row
        col_n.mid  = mid_a[MAG_BITS-1:0];
        col_n.sect = t_sector'(mid_a[MAG_BITS +: 2]);
        col_n.up   = r_s1_top ? mid_a[MAG_BITS-1:0] : abv_a[MAG_BITS-1:0];
        col_n.dn   = (r_s1_kind == KIND_DRAIN) ? mid_a[MAG_BITS-1:0] : r_s1_mag;

        col_e.mid  = mid_b[MAG_BITS-1:0];
        col_e.sect = t_sector'(mid_b[MAG_BITS +: 2]);
        col_e.up   = r_s1_top ? mid_b[MAG_BITS-1:0] : abv_b[MAG_BITS-1:0];
        col_e.dn   = mid_b[MAG_BITS-1:0];

        res0 = f_nms(r_win_b, r_s1_lc0 ? r_win_b : r_win_a, col_n);
        res1 = f_nms(col_n, r_s1_lc1 ? col_n : r_win_b, col_n);
        resd = f_nms(col_n, r_s1_first ? col_n : r_win_b, col_e);

        w0   = '{mag: MAG_W'(res0), last: 1'b0, eof: 1'b0};
        w1   = '{mag: MAG_W'(res1), last: 1'b1, eof: 1'b0};
        nres = 2'd0;
        case (r_s1_kind)
            KIND_PIXEL: begin
                if (r_s1_emit0 && r_s1_emit1) begin
                    nres = 2'd2;
                end else if (r_s1_emit0) begin
                    w0.last = 1'b1;
                    nres    = 2'd1;
                end else if (r_s1_emit1) begin
                    w0   = w1;
                    nres = 2'd1;
                end
            end
            KIND_DRAIN: begin
                w0   = '{mag: MAG_W'(resd), last: 1'b1, eof: r_s1_eof};
                nres = 2'd1;
            end
            default: ;
        endcase
    end

    // advance the window only for words that did real work
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            case (r_s1_kind)
                KIND_PIXEL: begin
                    r_win_a <= r_win_b;
                    r_win_b <= col_n;
                end
                KIND_DRAIN: r_win_b <= col_n;
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Output register, up to two result words
    //------------------------------------------------------------------
    assign out_free    = (r_out_cnt == 2'd0) || ((r_out_cnt == 2'd1) && o_res.ready);
    assign s1_adv      = r_s1_vld && out_free;
    assign i_pix.ready = !r_s1_vld || out_free;

    assign o_res.valid          = r_out_cnt != 2'd0;
    assign o_res.kept_magnitude = r_out0.mag;
    assign o_res.last_in_step   = r_out0.last;
    assign o_res.end_of_frame   = r_out0.eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= '0;
        end else if (s1_adv) begin
            r_out_cnt <= nres;
        end else if (o_res.valid && o_res.ready) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out0 <= w0;
            r_out1 <= w1;
        end else if (o_res.valid && o_res.ready) begin
            r_out0 <= r_out1;
        end
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_done_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_done |-> (r_col == '0))
        else $error("column counter not cleared while frame is complete");

    a_role_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur != 2'd3)
        else $error("line buffer role index out of range");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("output register overfilled");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_cnt == 2'd2) |-> !r_out0.last)
        else $error("first of two result words marked last");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.end_of_frame) |-> o_res.last_in_step)
        else $error("end of frame word not marked last");

endmodule

/* tb/gradient_non_max_suppression_tb.sv */
// Self-checking testbench for the streaming 3x3 gradient non-maximum suppression block.
module gradient_non_max_suppression_tb import gnms_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Slowest correct run: about 1k words, with the receiver stalling or the sender idle
    // 62 percent of the time, plus configuration pauses and one hold-off; the timeout
    // allows ten times that.
    localparam int unsigned TIMEOUT_CYCLES  = 100_000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int          RANDOM_WORDS    = 760;
    localparam int          IDLE_HEAVY      = 62;
    localparam int          IDLE_BOTH       = 37;

    // Directed 5x3 frame: field extremes, ties between neighbors, the angle wraparound,
    // both fold limits and every sector threshold from both sides.
    localparam logic [MAG_W-1:0] DIRECTED_MAGS [15] = '{
        16'hFFFF, 16'h0000, 16'd300, 16'd300, 16'hFFFF,
        16'd500, 16'h8000, 16'd500, 16'd1, 16'hFFFE,
        16'd300, 16'd300, 16'h0000, 16'd700, 16'hFFFF
    };
    localparam logic signed [ANGLE_W-1:0] DIRECTED_ANGLES [15] = '{
        16'sh8000, 16'sh7FFF, -16'sd25736, 16'sd25736, 16'sd0,
        -16'sd1, 16'sd3216, 16'sd3217, 16'sd9650, 16'sd9651,
        16'sd16084, 16'sd16085, 16'sd22518, 16'sd22519, -16'sd3217
    };

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last_in_step;
        logic             end_of_frame;
    } nms_result_t;

    class nms_scoreboard;
        logic [IMG_W_BITS-1:0] width_reg;
        logic [IMG_H_BITS-1:0] height_reg;
        logic [MAG_W-1:0]      row_above [DEF_MAX_WIDTH];
        logic [MAG_W-1:0]      row_mid [DEF_MAX_WIDTH];
        logic [MAG_W-1:0]      row_cur [DEF_MAX_WIDTH];
        t_sector               mid_sector [DEF_MAX_WIDTH];
        t_sector               cur_sector [DEF_MAX_WIDTH];
        int                    col;
        int                    row;
        int                    drain_col;
        bit                    frame_done;
        nms_result_t           pending_results[$];
        int                    errors;

        function new();
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            foreach (row_above[i]) begin
                row_above[i]  = '0;
                row_mid[i]    = '0;
                row_cur[i]    = '0;
                mid_sector[i] = SECT_HORZ;
                cur_sector[i] = SECT_HORZ;
            end
            col        = 0;
            row        = 0;
            drain_col  = 0;
            frame_done = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            if (idx == REG_IMG_WIDTH) width_reg = value[IMG_W_BITS-1:0];
            else height_reg = value[IMG_H_BITS-1:0];
        endfunction

        function int active_width();
            if (width_reg == 0) return 1;
            if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int active_height();
            if (height_reg == 0) return 1;
            if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
            return int'(height_reg);
        endfunction

        function t_sector sector_of(logic signed [ANGLE_W-1:0] angle);
            int a;
            a = angle;
            // add pi to negative angles; anything still negative stays horizontal
            if (a < 0) a += int'(PI_Q);
            if (a >= int'(SECT_D) || a < int'(SECT_A)) return SECT_HORZ;
            if (a < int'(SECT_B)) return SECT_DIAG_DN;
            if (a < int'(SECT_C)) return SECT_VERT;
            return SECT_DIAG_UP;
        endfunction

        // Thin one pixel of the middle row against its two neighbors along the sector.
        function logic [MAG_W-1:0] thin_at(int x, bit top, bit bottom);
            int               w;
            int               nx;
            int               dx [2];
            int               dy [2];
            logic [MAG_W-1:0] mag;
            logic [MAG_W-1:0] neighbor;
            bit               keep;
            w = active_width();
            if (x > w - 1) x = w - 1;
            case (mid_sector[x])
                SECT_HORZ: begin
                    dx = '{-1, 1};
                    dy = '{0, 0};
                end
                SECT_DIAG_DN: begin
                    dx = '{-1, 1};
                    dy = '{-1, 1};
                end
                SECT_VERT: begin
                    dx = '{0, 0};
                    dy = '{-1, 1};
                end
                default: begin
                    dx = '{1, -1};
                    dy = '{-1, 1};
                end
            endcase
            mag  = row_mid[x];
            keep = 1'b1;
            for (int k = 0; k < 2; k++) begin
                nx = x + dx[k];
                if (nx < 0) nx = 0;
                if (nx > w - 1) nx = w - 1;
                // missing rows at the frame edge are replaced by the middle row
                if (dy[k] < 0) neighbor = top ? row_mid[nx] : row_above[nx];
                else if (dy[k] > 0) neighbor = bottom ? row_mid[nx] : row_cur[nx];
                else neighbor = row_mid[nx];
                if (mag < neighbor) keep = 1'b0;
            end
            return keep ? mag : '0;
        endfunction

        function void add_result(logic [MAG_W-1:0] mag, bit last, bit eof);
            nms_result_t res;
            res.magnitude    = mag;
            res.last_in_step = last;
            res.end_of_frame = eof;
            pending_results.push_back(res);
        endfunction

        function void note_word(logic req, logic [MAG_W-1:0] mag,
                                logic signed [ANGLE_W-1:0] angle);
            int w;
            int h;
            int c;
            bit row_end;
            bit top;
            w = active_width();
            h = active_height();
            if (req == REQ_PIXEL) begin
                if (frame_done) return;
                c = (col > DEF_MAX_WIDTH - 1) ? DEF_MAX_WIDTH - 1 : col;
                row_cur[c]    = mag;
                cur_sector[c] = sector_of(angle);
                row_end = (c >= w - 1);
                if (row >= 1) begin
                    top = (row == 1);
                    if (c >= 1) add_result(thin_at(c - 1, top, 1'b0), !row_end, 1'b0);
                    if (row_end) add_result(thin_at(c, top, 1'b0), 1'b1, 1'b0);
                end
                if (row_end) begin
                    row_above  = row_mid;
                    row_mid    = row_cur;
                    mid_sector = cur_sector;
                    col        = 0;
                    if (row >= h - 1) frame_done = 1'b1;
                    else row++;
                end else begin
                    col = c + 1;
                end
            end else begin
                if (!frame_done) return;
                row_end = (drain_col >= w - 1);
                add_result(thin_at(drain_col, row == 0, 1'b1), 1'b1, row_end);
                if (row_end) begin
                    col        = 0;
                    row        = 0;
                    drain_col  = 0;
                    frame_done = 1'b0;
                end else begin
                    drain_col++;
                end
            end
        endfunction

        function void check_word(nms_result_t got);
            nms_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word: magnitude %0d last %0b eof %0b",
                         $time, got.magnitude, got.last_in_step, got.end_of_frame);
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (got.magnitude !== want.magnitude) begin
                errors++;
                $display("%0t: kept_magnitude mismatch: expected %0d, actual %0d",
                         $time, want.magnitude, got.magnitude);
            end
            if (got.last_in_step !== want.last_in_step) begin
                errors++;
                $display("%0t: last_in_step mismatch: expected %0b, actual %0b",
                         $time, want.last_in_step, got.last_in_step);
            end
            if (got.end_of_frame !== want.end_of_frame) begin
                errors++;
                $display("%0t: end_of_frame mismatch: expected %0b, actual %0b",
                         $time, want.end_of_frame, got.end_of_frame);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gnms_pix_if pix_bus ();
    gnms_res_if res_bus ();

    nms_scoreboard predictor;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          rx_hold_left = 0;
    int          rx_hold_req = 0;
    int          rx_hold_seen = 0;
    int          cfg_width;
    int          cfg_height;
    int          words_sent = 0;
    int unsigned cycle_count = 0;

    gradient_non_max_suppression u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off once requested.
    always @(posedge i_clk) begin
        if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = HOLD_OFF_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            predictor.check_word({res_bus.kept_magnitude, res_bus.last_in_step,
                                  res_bus.end_of_frame});
        end
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            predictor.note_word(pix_bus.req_type, pix_bus.grad_magnitude, pix_bus.grad_angle);
        end
    end

    function automatic logic [MAG_W-1:0] pick_magnitude();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return MAG_W'($urandom);
        // small values make ties with neighbors common
        if (roll < 80) return MAG_W'($urandom_range(15));
        return (roll < 90) ? '0 : '1;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        if ($urandom_range(99) < 10) return ANGLE_W'($urandom);
        return ANGLE_W'(int'($urandom_range(2 * int'(PI_Q))) - int'(PI_Q));
    endfunction

    function automatic int fit(int raw, int hi);
        return (raw < 1) ? 1 : ((raw > hi) ? hi : raw);
    endfunction

    task automatic send_word(logic req, logic [MAG_W-1:0] mag,
                             logic signed [ANGLE_W-1:0] angle);
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid          <= 1'b1;
        pix_bus.req_type       <= req;
        pix_bus.grad_magnitude <= mag;
        pix_bus.grad_angle     <= angle;
        do begin
            @(posedge i_clk);
        end while (!pix_bus.ready);
    endtask

    // Hold the sender until every expected word is out and the pipeline is empty.
    task automatic wait_drained();
        pix_bus.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (predictor.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        predictor.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic configure(int width_raw, int height_raw);
        cfg_width  = width_raw;
        cfg_height = height_raw;
        wait_drained();
        write_reg(REG_IMG_WIDTH, 32'(width_raw));
        write_reg(REG_IMG_HEIGHT, 32'(height_raw));
    endtask

    // One whole frame plus its drain words; noise adds ignored words in between.
    task automatic run_frame(bit noisy);
        int w;
        int h;
        w = fit(cfg_width, DEF_MAX_WIDTH);
        h = fit(cfg_height, HEIGHT_LIMIT);
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(99) < 5) begin
                send_word(REQ_DRAIN, pick_magnitude(), pick_angle());
            end
            send_word(REQ_PIXEL, pick_magnitude(), pick_angle());
        end
        if (noisy && $urandom_range(99) < 30) begin
            send_word(REQ_PIXEL, pick_magnitude(), pick_angle());
        end
        for (int i = 0; i < w; i++) begin
            if (noisy && $urandom_range(99) < 5) begin
                send_word(REQ_PIXEL, pick_magnitude(), pick_angle());
            end
            send_word(REQ_DRAIN, pick_magnitude(), pick_angle());
        end
        words_sent += w * h + w;
    endtask

    initial begin
        int roll;
        int w_raw;
        int h_raw;
        predictor              = new();
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        pix_bus.valid          = 1'b0;
        pix_bus.req_type       = REQ_PIXEL;
        pix_bus.grad_magnitude = '0;
        pix_bus.grad_angle     = '0;
        tx_idle_pct            = 0;
        rx_stall_pct           = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(5, 3);
        // drain before the frame is complete: consumed, no result
        send_word(REQ_DRAIN, '1, '0);
        for (int i = 0; i < 15; i++) send_word(REQ_PIXEL, DIRECTED_MAGS[i], DIRECTED_ANGLES[i]);
        // pixel after the frame is complete: consumed, no result
        send_word(REQ_PIXEL, '1, 16'sh7FFF);
        for (int i = 0; i < 5; i++) send_word(REQ_DRAIN, '0, '1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    // let the output back up while words keep arriving
                    rx_hold_req++;
                end
                1: begin
                    tx_idle_pct  = IDLE_HEAVY;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = IDLE_HEAVY;
                end
                default: begin
                    tx_idle_pct  = IDLE_BOTH;
                    rx_stall_pct = IDLE_BOTH;
                end
            endcase
            while (words_sent < (phase + 1) * RANDOM_WORDS / 4) begin
                if ($urandom_range(2) == 0) begin
                    roll  = $urandom_range(99);
                    w_raw = (roll < 10) ? int'($urandom_range(1)) :
                            (roll < 75) ? int'($urandom_range(8, 2)) :
                                          int'($urandom_range(40, 9));
                    roll  = $urandom_range(99);
                    h_raw = (roll < 10) ? int'($urandom_range(1)) : int'($urandom_range(5, 2));
                    configure(w_raw, h_raw);
                end
                run_frame(1'b1);
            end
            wait_drained();
        end

        // zero register values saturate to one column or one row
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        configure(0, 6);
        run_frame(1'b0);
        configure(24, 0);
        run_frame(1'b0);

        wait_drained();
        if (predictor.errors == 0 && predictor.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
